// ===== hw/rtl/mcsp_pkg.sv =====
package mcsp_pkg;

    localparam logic [15:0] ID_MAIN     = 16'h4d4d;
    localparam logic [15:0] ID_EDITOR   = 16'h3d3d;
    localparam logic [15:0] ID_OBJECT   = 16'h4000;
    localparam logic [15:0] ID_MESH     = 16'h4100;
    localparam logic [15:0] ID_VERTICES = 16'h4110;
    localparam logic [15:0] ID_FACES    = 16'h4120;
    localparam logic [31:0] HEADER_BYTES = 32'd6;

    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_VCOUNT = 3'd1;
    localparam logic [2:0] KIND_VCOORD = 3'd2;
    localparam logic [2:0] KIND_FCOUNT = 3'd3;
    localparam logic [2:0] KIND_FINDEX = 3'd4;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_NAME   = 7'b0000010,
        PH_VCOUNT = 7'b0000100,
        PH_VDATA  = 7'b0001000,
        PH_FCOUNT = 7'b0010000,
        PH_FDATA  = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [15:0] element_number;
        logic [1:0]  component;
        logic        name_end;
        logic        object_done;
    } t_result;

    function automatic logic [31:0] gather(input logic [31:0] word, input logic [7:0] b,
                                           input logic [1:0] pos);
        logic [31:0] shifted;
        shifted = {24'd0, b} << {pos, 3'b000};
        if (pos == 2'd0) begin
            gather = {24'd0, b};
        end else begin
            gather = word | shifted;
        end
    endfunction

endpackage

// ===== hw/rtl/mcsp_parser.sv =====
module mcsp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output mcsp_pkg::t_result o_res
);

    mcsp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_aw, n_aw;
    logic [15:0] r_id, n_id;
    logic [15:0] r_left, n_left;
    logic [15:0] r_idx, n_idx;
    logic [1:0]  r_wie, n_wie;
    logic [31:0] r_skip, n_skip;

    logic [1:0]  hpos;
    logic [31:0] len_word;
    logic [15:0] cnt;
    logic        faces;

    assign hpos     = r_pos[1:0] - 2'd2;
    assign len_word = mcsp_pkg::gather(r_aw, i_byte, hpos);
    assign cnt      = {i_byte, r_aw[7:0]};
    assign faces    = (r_phase == mcsp_pkg::PH_FCOUNT);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_aw    = r_aw;
        n_id    = r_id;
        n_left  = r_left;
        n_idx   = r_idx;
        n_wie   = r_wie;
        n_skip  = r_skip;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            case (r_phase)
                mcsp_pkg::PH_NAME: begin
                    o_res_valid    = 1'b1;
                    o_res.kind     = mcsp_pkg::KIND_NAME;
                    o_res.value    = {24'd0, i_byte};
                    o_res.name_end = (i_byte == 8'd0);
                    if (i_byte == 8'd0) begin
                        n_phase = mcsp_pkg::PH_HEADER;
                    end
                end
                mcsp_pkg::PH_VCOUNT, mcsp_pkg::PH_FCOUNT: begin
                    n_aw = mcsp_pkg::gather(r_aw, i_byte, {1'b0, r_pos[0]});
                    if (r_pos[0] == 1'b0) begin
                        n_pos = 3'd1;
                    end else begin
                        n_pos  = 3'd0;
                        n_left = cnt;
                        n_idx  = 16'd0;
                        n_wie  = 2'd0;
                        o_res_valid       = 1'b1;
                        o_res.kind        = faces ? mcsp_pkg::KIND_FCOUNT
                                                  : mcsp_pkg::KIND_VCOUNT;
                        o_res.value       = {16'd0, cnt};
                        o_res.object_done = faces && (cnt == 16'd0);
                        if (cnt == 16'd0) begin
                            n_phase = mcsp_pkg::PH_HEADER;
                        end else if (faces) begin
                            n_phase = mcsp_pkg::PH_FDATA;
                        end else begin
                            n_phase = mcsp_pkg::PH_VDATA;
                        end
                    end
                end
                mcsp_pkg::PH_VDATA: begin
                    n_aw = mcsp_pkg::gather(r_aw, i_byte, r_pos[1:0]);
                    if (r_pos < 3'd3) begin
                        n_pos = r_pos + 3'd1;
                    end else begin
                        n_pos = 3'd0;
                        o_res_valid          = 1'b1;
                        o_res.kind           = mcsp_pkg::KIND_VCOORD;
                        o_res.value          = n_aw;
                        o_res.element_number = r_idx;
                        o_res.component      = r_wie;
                        if (r_wie >= 2'd2) begin
                            n_wie  = 2'd0;
                            n_idx  = r_idx + 16'd1;
                            n_left = r_left - 16'd1;
                            if (r_left == 16'd1) begin
                                n_phase = mcsp_pkg::PH_HEADER;
                            end
                        end else begin
                            n_wie = r_wie + 2'd1;
                        end
                    end
                end
                mcsp_pkg::PH_FDATA: begin
                    n_aw = mcsp_pkg::gather(r_aw, i_byte, {1'b0, r_pos[0]});
                    if (r_pos[0] == 1'b0) begin
                        n_pos = 3'd1;
                    end else begin
                        n_pos = 3'd0;
                        if (r_wie != 2'd3) begin
                            o_res_valid          = 1'b1;
                            o_res.kind           = mcsp_pkg::KIND_FINDEX;
                            o_res.value          = {16'd0, n_aw[15:0]};
                            o_res.element_number = r_idx;
                            o_res.component      = r_wie;
                            o_res.object_done    = (r_wie == 2'd2) && (r_left == 16'd1);
                            n_wie = r_wie + 2'd1;
                        end else begin
                            n_wie  = 2'd0;
                            n_idx  = r_idx + 16'd1;
                            n_left = r_left - 16'd1;
                            if (r_left == 16'd1) begin
                                n_phase = mcsp_pkg::PH_HEADER;
                            end
                        end
                    end
                end
                mcsp_pkg::PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_phase = mcsp_pkg::PH_HEADER;
                    end
                end
                default: begin
                    if (r_pos < 3'd2) begin
                        n_aw  = mcsp_pkg::gather(r_aw, i_byte, r_pos[1:0]);
                        n_pos = r_pos + 3'd1;
                        if (r_pos == 3'd1) begin
                            n_id = n_aw[15:0];
                        end
                    end else begin
                        n_aw = len_word;
                        if (r_pos < 3'd5) begin
                            n_pos = r_pos + 3'd1;
                        end else begin
                            n_pos   = 3'd0;
                            n_phase = mcsp_pkg::PH_HEADER;
                            if (r_id == mcsp_pkg::ID_OBJECT) begin
                                n_phase = mcsp_pkg::PH_NAME;
                            end else if (r_id == mcsp_pkg::ID_VERTICES) begin
                                n_phase = mcsp_pkg::PH_VCOUNT;
                            end else if (r_id == mcsp_pkg::ID_FACES) begin
                                n_phase = mcsp_pkg::PH_FCOUNT;
                            end else if (r_id != mcsp_pkg::ID_MAIN &&
                                         r_id != mcsp_pkg::ID_EDITOR &&
                                         r_id != mcsp_pkg::ID_MESH) begin
                                if (len_word > mcsp_pkg::HEADER_BYTES) begin
                                    n_skip  = len_word - mcsp_pkg::HEADER_BYTES;
                                    n_phase = mcsp_pkg::PH_SKIP;
                                end else begin
                                    n_skip = 32'd0;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mcsp_pkg::PH_HEADER;
            r_pos   <= 3'd0;
            r_aw    <= 32'd0;
            r_id    <= 16'd0;
            r_left  <= 16'd0;
            r_idx   <= 16'd0;
            r_wie   <= 2'd0;
            r_skip  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_aw    <= n_aw;
            r_id    <= n_id;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_wie   <= n_wie;
            r_skip  <= n_skip;
        end
    end

endmodule

// ===== hw/rtl/mesh_chunk_stream_parser_core.sv =====
// Channel   Direction  Ports                       Payload
// s         in         i_s_tvalid/o_s_tready       tdata: data_byte
// m         out        o_m_tvalid/i_m_tready       tdata: value, element_number, component
//                                                  tuser: kind, name_end; tlast: object_done
//
// One byte per cycle while the result side is not stalled; a result appears in the cycle after its byte.
// The parse state updates as the byte is taken; the result register holds one word.
// A stalled result register blocks input only while it is full and not being taken.
// Reset (synchronous, active low) returns to the chunk header phase with all parser state zero and no result held.
module mesh_chunk_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [31:0] value, [47:32] element_number, [49:48] component
    output logic [3:0]  o_m_tuser,   // [2:0] kind, [3] name_end
    output logic        o_m_tlast    // object_done
);

    logic              accept;
    logic              res_valid;
    mcsp_pkg::t_result res;
    logic              r_m_valid;
    mcsp_pkg::t_result r_m_res;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    mcsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_m_valid <= accept && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_res.component, r_m_res.element_number, r_m_res.value};
    assign o_m_tuser  = {r_m_res.name_end, r_m_res.kind};
    assign o_m_tlast  = r_m_res.object_done;

endmodule

// ===== test/mesh_chunk_stream_parser_checker.sv =====
module mesh_chunk_stream_parser_checker
    import mcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // [31:0] value, [47:32] element_number, [49:48] component
    input  logic [3:0]  i_m_tuser,   // [2:0] kind, [3] name_end
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_words_due
);

    timeunit 1ns;
    timeprecision 1ps;

    t_phase      phase;
    logic [2:0]  byte_pos;
    logic [31:0] word_acc;
    logic [15:0] chunk_id;
    logic [15:0] elems_left;
    logic [15:0] elem_idx;
    logic [1:0]  word_idx;
    logic [31:0] skip_left;

    t_result     words_due[$];
    int          errors = 0;

    assign o_fail_count = errors;

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [31:0] fold_byte(input logic [31:0] acc, input logic [7:0] b,
                                              input logic [1:0] pos);
        if (pos == 2'd0) begin
            return {24'd0, b};
        end
        return acc | ({24'd0, b} << (8 * pos));
    endfunction

    task automatic advance_parser(input logic [7:0] b);
        logic [2:0] pos;
        logic [1:0] w;
        logic       faces;
        t_result    r;
        pos   = byte_pos;
        w     = word_idx;
        faces = (phase == PH_FCOUNT);
        r     = '0;
        case (phase)
            PH_NAME: begin
                r.kind     = KIND_NAME;
                r.value    = {24'd0, b};
                r.name_end = (b == 8'd0);
                words_due.push_back(r);
                if (b == 8'd0) begin
                    phase = PH_HEADER;
                end
            end
            PH_VCOUNT, PH_FCOUNT: begin
                word_acc = fold_byte(word_acc, b, {1'b0, pos[0]});
                if (pos == 3'd0) begin
                    byte_pos = 3'd1;
                end else begin
                    byte_pos      = 3'd0;
                    elems_left    = word_acc[15:0];
                    elem_idx      = 16'd0;
                    word_idx      = 2'd0;
                    r.kind        = faces ? KIND_FCOUNT : KIND_VCOUNT;
                    r.value       = {16'd0, elems_left};
                    r.object_done = faces && (elems_left == 16'd0);
                    words_due.push_back(r);
                    if (elems_left == 16'd0) begin
                        phase = PH_HEADER;
                    end else if (faces) begin
                        phase = PH_FDATA;
                    end else begin
                        phase = PH_VDATA;
                    end
                end
            end
            PH_VDATA: begin
                word_acc = fold_byte(word_acc, b, pos[1:0]);
                if (pos < 3'd3) begin
                    byte_pos = pos + 3'd1;
                end else begin
                    byte_pos         = 3'd0;
                    r.kind           = KIND_VCOORD;
                    r.value          = word_acc;
                    r.element_number = elem_idx;
                    r.component      = w;
                    words_due.push_back(r);
                    if (w >= 2'd2) begin
                        word_idx   = 2'd0;
                        elem_idx   = elem_idx + 16'd1;
                        elems_left = elems_left - 16'd1;
                        if (elems_left == 16'd0) begin
                            phase = PH_HEADER;
                        end
                    end else begin
                        word_idx = w + 2'd1;
                    end
                end
            end
            PH_FDATA: begin
                word_acc = fold_byte(word_acc, b, {1'b0, pos[0]});
                if (pos == 3'd0) begin
                    byte_pos = 3'd1;
                end else begin
                    byte_pos = 3'd0;
                    if (w < 2'd3) begin
                        r.kind           = KIND_FINDEX;
                        r.value          = {16'd0, word_acc[15:0]};
                        r.element_number = elem_idx;
                        r.component      = w;
                        r.object_done    = (w == 2'd2) && (elems_left == 16'd1);
                        words_due.push_back(r);
                        word_idx = w + 2'd1;
                    end else begin
                        // drop the fourth word of the face
                        word_idx   = 2'd0;
                        elem_idx   = elem_idx + 16'd1;
                        elems_left = elems_left - 16'd1;
                        if (elems_left == 16'd0) begin
                            phase = PH_HEADER;
                        end
                    end
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 32'd0) begin
                    phase = PH_HEADER;
                end
            end
            default: begin
                if (pos < 3'd2) begin
                    word_acc = fold_byte(word_acc, b, pos[1:0]);
                    if (pos == 3'd1) begin
                        chunk_id = word_acc[15:0];
                    end
                    byte_pos = pos + 3'd1;
                end else begin
                    word_acc = fold_byte(word_acc, b, pos[1:0] - 2'd2);
                    if (pos < 3'd5) begin
                        byte_pos = pos + 3'd1;
                    end else begin
                        byte_pos = 3'd0;
                        case (chunk_id)
                            ID_MAIN, ID_EDITOR, ID_MESH: phase = PH_HEADER;
                            ID_OBJECT:   phase = PH_NAME;
                            ID_VERTICES: phase = PH_VCOUNT;
                            ID_FACES:    phase = PH_FCOUNT;
                            default: begin
                                skip_left = (word_acc >= HEADER_BYTES) ?
                                            word_acc - HEADER_BYTES : 32'd0;
                                phase = (skip_left == 32'd0) ? PH_HEADER : PH_SKIP;
                            end
                        endcase
                    end
                end
            end
        endcase
    endtask

    task automatic check_word();
        t_result want;
        if (words_due.size() == 0) begin
            report_error($sformatf("unexpected word, value %0h kind %0d",
                                   i_m_tdata[31:0], i_m_tuser[2:0]));
            return;
        end
        want = words_due.pop_front();
        if (i_m_tuser[2:0] !== want.kind) begin
            report_error($sformatf("kind: got %0d, expected %0d", i_m_tuser[2:0], want.kind));
        end
        if (i_m_tdata[31:0] !== want.value) begin
            report_error($sformatf("value: got %0h, expected %0h",
                                   i_m_tdata[31:0], want.value));
        end
        if (i_m_tdata[47:32] !== want.element_number) begin
            report_error($sformatf("element_number: got %0d, expected %0d",
                                   i_m_tdata[47:32], want.element_number));
        end
        if (i_m_tdata[49:48] !== want.component) begin
            report_error($sformatf("component: got %0d, expected %0d",
                                   i_m_tdata[49:48], want.component));
        end
        if (i_m_tuser[3] !== want.name_end) begin
            report_error($sformatf("name_end: got %0b, expected %0b",
                                   i_m_tuser[3], want.name_end));
        end
        if (i_m_tlast !== want.object_done) begin
            report_error($sformatf("object_done: got %0b, expected %0b",
                                   i_m_tlast, want.object_done));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_HEADER;
            byte_pos   = 3'd0;
            word_acc   = 32'd0;
            chunk_id   = 16'd0;
            elems_left = 16'd0;
            elem_idx   = 16'd0;
            word_idx   = 2'd0;
            skip_left  = 32'd0;
            words_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_parser(i_s_tdata);
            end
        end
        o_words_due <= words_due.size();
    end

endmodule

// ===== test/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mcsp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          words_due;

    logic [7:0]  file_bytes[$];
    int          bytes_sent = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          hold_results = 1'b0;

    always #2 i_clk = ~i_clk;

    mesh_chunk_stream_parser_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    mesh_chunk_stream_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    task automatic add_u16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic add_header(input logic [15:0] id, input logic [31:0] len);
        add_u16(id);
        add_u16(len[15:0]);
        add_u16(len[31:16]);
    endtask

    task automatic add_name(input int unsigned chars);
        repeat (chars) file_bytes.push_back(8'($urandom_range(1, 255)));
        file_bytes.push_back(8'd0);
    endtask

    task automatic add_vertex_chunk(input int unsigned count);
        add_header(ID_VERTICES, 8 + 12 * count);
        add_u16(16'(count));
        repeat (12 * count) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_face_chunk(input int unsigned count, input int unsigned faces);
        add_header(ID_FACES, 8 + 8 * count);
        add_u16(16'(count));
        repeat (4 * faces) add_u16(16'($urandom_range(0, 16'hffff)));
    endtask

    task automatic add_foreign_chunk();
        logic [15:0] id;
        int unsigned len;
        do begin
            id = 16'($urandom_range(0, 16'hffff));
        end while (id == ID_MAIN || id == ID_EDITOR || id == ID_OBJECT ||
                   id == ID_MESH || id == ID_VERTICES || id == ID_FACES);
        if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(0, 5);
        end else begin
            len = 6 + $urandom_range(0, 16);
        end
        add_header(id, len);
        repeat ((len > 6) ? len - 6 : 0) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_model();
        int unsigned objects;
        int unsigned faces;
        objects = $urandom_range(1, 3);
        add_header(ID_MAIN, $urandom);
        add_header(ID_EDITOR, $urandom);
        repeat (objects) begin
            if ($urandom_range(0, 3) == 0) begin
                add_foreign_chunk();
            end
            add_header(ID_OBJECT, $urandom);
            add_name($urandom_range(0, 12));
            add_header(ID_MESH, $urandom);
            if ($urandom_range(0, 5) != 0) begin
                add_vertex_chunk($urandom_range(0, 5));
            end
            if ($urandom_range(0, 4) == 0) begin
                add_foreign_chunk();
            end
            if ($urandom_range(0, 5) != 0) begin
                faces = $urandom_range(0, 5);
                add_face_chunk(faces, faces);
            end
        end
    endtask

    task automatic stream_out();
        logic [7:0] b;
        while (file_bytes.size() != 0) begin
            b = file_bytes.pop_front();
            if (src_gaps && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do @(negedge i_clk); while (!s_tready);
            @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);
        @(posedge i_clk);
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_face_chunk(0, 0);
        add_vertex_chunk(0);
        add_header(16'hffff, 32'd3);
        add_header(ID_OBJECT, 32'hffff_ffff);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'd0);
        stream_out();
        wait_drained();

        // stall the result side while a whole model is offered
        hold_results = 1'b1;
        add_model();
        stream_out();
        wait_drained();

        while (bytes_sent < 650) begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            add_model();
            stream_out();
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
        end

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        add_model();
        // leave the stream inside a face chunk with the largest count
        add_face_chunk(16'hffff, 3);
        stream_out();
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
